@@ hdl/wac_pkg.sv @@
// shared types, constants and command/status bundles for the alert correlator
package wac_pkg;

    localparam int NOW_W      = 32;
    localparam int CLS_W      = 3;
    localparam int THR_W      = 7;
    localparam int SEEN_W     = 7;
    localparam int CONF_W     = 17;
    localparam int CTR_W      = 32;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int DIV_STEPS  = 16;
    localparam int DIV_CNT_W  = 5;

    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int TIME_BITS_DEF    = 32;

    localparam logic [NOW_W-1:0]  WLEN_RESET     = 32'd1000;
    localparam logic [THR_W-1:0]  THR_RESET      = 7'd5;
    localparam logic [CONF_W-1:0] CONF_IMMEDIATE = 17'd39322;
    localparam logic [CONF_W-1:0] CONF_ONE       = 17'h10000;

    localparam logic [CLS_W-1:0] CLS_NORMAL = 3'd0;
    localparam logic [CLS_W-1:0] CLS_DOS    = 3'd1;
    localparam logic [CLS_W-1:0] CLS_PROBE  = 3'd2;
    localparam logic [CLS_W-1:0] CLS_R2L    = 3'd3;
    localparam logic [CLS_W-1:0] CLS_U2R    = 3'd4;

    localparam logic CMD_ALERT = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic REG_WLEN = 1'b0;
    localparam logic REG_THR  = 1'b1;

    typedef struct packed {
        logic load;
        logic alert;
        logic pop;
        logic scan_start;
        logic scan;
        logic pick;
        logic div_step;
        logic corr_done;
        logic res_none;
        logic out_load;
    } ctl_t;

    typedef struct packed {
        logic prune_go;
        logic entry_old;
        logic thr_met;
        logic scan_done;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

@@ hdl/wac_ctrl.sv @@
// sequencing state machine for alert appends and correlation ticks
module wac_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    input  logic          cmd,
    input  wac_pkg::sts_t sts,
    output wac_pkg::ctl_t ctl
);
    import wac_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALERT,
        ST_PRUNE_RD,
        ST_PRUNE_CHK,
        ST_THRESH,
        ST_SCAN,
        ST_PICK,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   item_ready_reg;

    assign item_ready = item_ready_reg;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid && item_ready_reg)
                begin
                    ctl.load   = 1'b1;
                    state_next = (cmd == CMD_TICK) ? ST_PRUNE_RD : ST_ALERT;
                end
            end
            ST_ALERT:
            begin
                ctl.alert  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_PRUNE_RD:
            begin
                state_next = sts.prune_go ? ST_PRUNE_CHK : ST_THRESH;
            end
            ST_PRUNE_CHK:
            begin
                if (sts.entry_old)
                begin
                    ctl.pop    = 1'b1;
                    state_next = ST_PRUNE_RD;
                end
                else
                begin
                    state_next = ST_THRESH;
                end
            end
            ST_THRESH:
            begin
                if (sts.thr_met)
                begin
                    ctl.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    ctl.res_none = 1'b1;
                    state_next   = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_PICK;
                end
                else
                begin
                    ctl.scan = 1'b1;
                end
            end
            ST_PICK:
            begin
                ctl.pick   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    ctl.corr_done = 1'b1;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    ctl.div_step = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            item_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            item_ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

@@ hdl/wac_dpath.sv @@
// window memory, pointers, class tally, divider, counters and result register
module wac_dpath #(
    parameter int WINDOW_DEPTH = wac_pkg::WINDOW_DEPTH_DEF,
    parameter int TIME_BITS    = wac_pkg::TIME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wac_pkg::ctl_t                 ctl,
    output wac_pkg::sts_t                 sts,
    input  logic [wac_pkg::NOW_W-1:0]     window_length,
    input  logic [wac_pkg::THR_W-1:0]     alert_threshold,
    input  logic [wac_pkg::NOW_W-1:0]     now,
    input  logic [wac_pkg::CLS_W-1:0]     detected_class,
    input  logic [wac_pkg::CLS_W-1:0]     actual_class,
    input  logic                          force_escalate,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic                          escalated,
    output logic                          escalation_kind,
    output logic [wac_pkg::CTR_W-1:0]     escalation_id,
    output logic [wac_pkg::CLS_W-1:0]     tentative_class,
    output logic [wac_pkg::SEEN_W-1:0]    alerts_seen,
    output logic [wac_pkg::CONF_W-1:0]    confidence,
    output logic                          alert_fired,
    output logic [wac_pkg::CTR_W-1:0]     true_pos,
    output logic [wac_pkg::CTR_W-1:0]     false_pos,
    output logic [wac_pkg::CTR_W-1:0]     false_neg,
    output logic [wac_pkg::CTR_W-1:0]     true_neg
);
    import wac_pkg::*;

    localparam int HW    = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int TW    = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;
    localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;
    localparam int ENT_W = TW + CLS_W;

    // window store: arrival time and detected class
    logic [ENT_W-1:0] mem [WINDOW_DEPTH];
    logic [ENT_W-1:0] rdata_reg;
    logic [HW-1:0]    raddr;

    logic [HW-1:0]    head_reg;
    logic [CNT_W-1:0] count_reg;

    logic [TW-1:0]    now_t_reg;
    logic [CLS_W-1:0] det_reg;
    logic [CLS_W-1:0] act_reg;
    logic             force_reg;
    logic             prune_en_reg;
    logic [NOW_W-1:0] cutoff_reg;

    logic [HW-1:0]    scan_ptr_reg;
    logic [CNT_W-1:0] scan_left_reg;
    logic             rd_v_reg;
    logic [CNT_W-1:0] cls_cnt_reg [4];

    logic [CLS_W-1:0]     dom_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CONF_W-1:0]    quo_reg;
    logic [DIV_CNT_W-1:0] div_left_reg;

    logic [CTR_W-1:0] esc_cnt_reg;
    logic [CTR_W-1:0] tp_reg;
    logic [CTR_W-1:0] fp_reg;
    logic [CTR_W-1:0] fn_reg;
    logic [CTR_W-1:0] tn_reg;

    logic              res_esc_reg;
    logic              res_kind_reg;
    logic [CTR_W-1:0]  res_id_reg;
    logic [CLS_W-1:0]  res_cls_reg;
    logic [SEEN_W-1:0] res_seen_reg;
    logic [CONF_W-1:0] res_conf_reg;
    logic              res_fired_reg;

    logic              out_valid_reg;
    logic              out_esc_reg;
    logic              out_kind_reg;
    logic [CTR_W-1:0]  out_id_reg;
    logic [CLS_W-1:0]  out_cls_reg;
    logic [SEEN_W-1:0] out_seen_reg;
    logic [CONF_W-1:0] out_conf_reg;
    logic              out_fired_reg;
    logic [CTR_W-1:0]  out_tp_reg;
    logic [CTR_W-1:0]  out_fp_reg;
    logic [CTR_W-1:0]  out_fn_reg;
    logic [CTR_W-1:0]  out_tn_reg;

    logic [NOW_W-1:0] now_m;
    logic [HW-1:0]    head_inc;
    logic [HW-1:0]    scan_inc;
    logic             full;
    logic [HW-1:0]    head_a;
    logic [CNT_W-1:0] count_a;
    logic [CNT_W-1:0] count_next;
    logic [HW:0]      pos_sum;
    logic [HW-1:0]    pos;
    logic             fired;
    logic             attack;
    logic             esc_a;
    logic [CTR_W-1:0] esc_id_next;
    logic [NOW_W-1:0] rd_time;
    logic [CLS_W-1:0] rd_cls;
    logic [CLS_W-1:0] dom_c;
    logic [CNT_W-1:0] maxc_c;
    logic [CNT_W:0]   rem_sh;
    logic             rem_ge;

    assign now_m    = NOW_W'(now[TW-1:0]);
    assign head_inc = (head_reg == HW'(WINDOW_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign scan_inc = (scan_ptr_reg == HW'(WINDOW_DEPTH - 1)) ? '0 : scan_ptr_reg + 1'b1;

    // a full window drops its oldest entry before the append
    assign full       = (count_reg == CNT_W'(WINDOW_DEPTH));
    assign head_a     = full ? head_inc : head_reg;
    assign count_a    = full ? CNT_W'(WINDOW_DEPTH - 1) : count_reg;
    assign count_next = count_a + 1'b1;
    assign pos_sum    = {1'b0, head_a} + (HW + 1)'(count_a);
    assign pos        = (pos_sum >= (HW + 1)'(WINDOW_DEPTH))
                        ? HW'(pos_sum - (HW + 1)'(WINDOW_DEPTH)) : HW'(pos_sum);

    assign fired       = (det_reg != CLS_NORMAL);
    assign attack      = (act_reg != CLS_NORMAL);
    assign esc_a       = force_reg || (det_reg == CLS_R2L) || (det_reg == CLS_U2R);
    assign esc_id_next = (esc_cnt_reg == '1) ? esc_cnt_reg : esc_cnt_reg + 1'b1;

    assign rd_time = NOW_W'(rdata_reg[ENT_W-1:CLS_W]);
    assign rd_cls  = rdata_reg[CLS_W-1:0];
    assign raddr   = ctl.scan ? scan_ptr_reg : head_reg;

    // dominant class, ties resolved toward the lower code
    always_comb
    begin
        dom_c  = CLS_DOS;
        maxc_c = cls_cnt_reg[0];
        if (cls_cnt_reg[1] > maxc_c)
        begin
            dom_c  = CLS_PROBE;
            maxc_c = cls_cnt_reg[1];
        end
        if (cls_cnt_reg[2] > maxc_c)
        begin
            dom_c  = CLS_R2L;
            maxc_c = cls_cnt_reg[2];
        end
        if (cls_cnt_reg[3] > maxc_c)
        begin
            dom_c  = CLS_U2R;
            maxc_c = cls_cnt_reg[3];
        end
    end

    // restoring divide, one quotient bit per step
    assign rem_sh = {rem_reg, 1'b0};
    assign rem_ge = (rem_sh >= {1'b0, count_reg});

    assign sts.prune_go  = prune_en_reg && (count_reg != '0);
    assign sts.entry_old = (rd_time < cutoff_reg);
    assign sts.thr_met   = (CMP_W'(count_reg) >= CMP_W'(alert_threshold));
    assign sts.scan_done = (scan_left_reg == '0) && !rd_v_reg;
    assign sts.div_done  = (div_left_reg == '0);
    assign sts.out_free  = !out_valid_reg || result_ready;

    always_ff @(posedge clk)
    begin
        if (ctl.alert)
        begin
            mem[pos] <= {now_t_reg, det_reg};
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            esc_cnt_reg   <= '0;
            tp_reg        <= '0;
            fp_reg        <= '0;
            fn_reg        <= '0;
            tn_reg        <= '0;
            scan_left_reg <= '0;
            rd_v_reg      <= 1'b0;
            div_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.alert)
            begin
                head_reg  <= head_a;
                count_reg <= count_next;
                if (attack && fired)
                begin
                    tp_reg <= (tp_reg == '1) ? tp_reg : tp_reg + 1'b1;
                end
                else if (!attack && fired)
                begin
                    fp_reg <= (fp_reg == '1) ? fp_reg : fp_reg + 1'b1;
                end
                else if (attack && !fired)
                begin
                    fn_reg <= (fn_reg == '1) ? fn_reg : fn_reg + 1'b1;
                end
                else
                begin
                    tn_reg <= (tn_reg == '1) ? tn_reg : tn_reg + 1'b1;
                end
                if (esc_a)
                begin
                    esc_cnt_reg <= esc_id_next;
                end
            end
            else if (ctl.pop)
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
            end
            else if (ctl.corr_done)
            begin
                head_reg    <= '0;
                count_reg   <= '0;
                esc_cnt_reg <= esc_id_next;
            end

            if (ctl.scan_start)
            begin
                scan_left_reg <= count_reg;
                rd_v_reg      <= 1'b0;
            end
            else if (ctl.scan)
            begin
                if (scan_left_reg != '0)
                begin
                    scan_left_reg <= scan_left_reg - 1'b1;
                    rd_v_reg      <= 1'b1;
                end
                else
                begin
                    rd_v_reg <= 1'b0;
                end
            end

            if (ctl.pick)
            begin
                if ((count_reg == '0) || (maxc_c == count_reg))
                begin
                    div_left_reg <= '0;
                end
                else
                begin
                    div_left_reg <= DIV_CNT_W'(DIV_STEPS);
                end
            end
            else if (ctl.div_step)
            begin
                div_left_reg <= div_left_reg - 1'b1;
            end

            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            now_t_reg    <= now[TW-1:0];
            det_reg      <= detected_class;
            act_reg      <= actual_class;
            force_reg    <= force_escalate;
            prune_en_reg <= (now_m >= window_length);
            cutoff_reg   <= now_m - window_length;
        end

        if (ctl.scan_start)
        begin
            scan_ptr_reg   <= head_reg;
            cls_cnt_reg[0] <= '0;
            cls_cnt_reg[1] <= '0;
            cls_cnt_reg[2] <= '0;
            cls_cnt_reg[3] <= '0;
        end
        else if (ctl.scan)
        begin
            if (scan_left_reg != '0)
            begin
                scan_ptr_reg <= scan_inc;
            end
            if (rd_v_reg)
            begin
                // codes outside dos..u2r are not tallied
                unique case (rd_cls)
                    CLS_DOS:   cls_cnt_reg[0] <= cls_cnt_reg[0] + 1'b1;
                    CLS_PROBE: cls_cnt_reg[1] <= cls_cnt_reg[1] + 1'b1;
                    CLS_R2L:   cls_cnt_reg[2] <= cls_cnt_reg[2] + 1'b1;
                    CLS_U2R:   cls_cnt_reg[3] <= cls_cnt_reg[3] + 1'b1;
                    default:   ;
                endcase
            end
        end

        if (ctl.pick)
        begin
            dom_reg <= dom_c;
            rem_reg <= maxc_c;
            if (count_reg == '0)
            begin
                quo_reg <= '0;
            end
            else if (maxc_c == count_reg)
            begin
                quo_reg <= CONF_ONE;
            end
            else
            begin
                quo_reg <= '0;
            end
        end
        else if (ctl.div_step)
        begin
            rem_reg <= rem_ge ? CNT_W'(rem_sh - {1'b0, count_reg}) : CNT_W'(rem_sh);
            quo_reg <= {quo_reg[CONF_W-2:0], rem_ge};
        end

        if (ctl.alert)
        begin
            res_esc_reg   <= esc_a;
            res_kind_reg  <= 1'b0;
            res_id_reg    <= esc_a ? esc_id_next : '0;
            res_cls_reg   <= esc_a ? det_reg : CLS_NORMAL;
            res_seen_reg  <= esc_a ? SEEN_W'(count_next) : '0;
            res_conf_reg  <= esc_a ? CONF_IMMEDIATE : '0;
            res_fired_reg <= fired;
        end
        else if (ctl.corr_done)
        begin
            res_esc_reg   <= 1'b1;
            res_kind_reg  <= 1'b1;
            res_id_reg    <= esc_id_next;
            res_cls_reg   <= dom_reg;
            res_seen_reg  <= SEEN_W'(count_reg);
            res_conf_reg  <= quo_reg;
            res_fired_reg <= 1'b0;
        end
        else if (ctl.res_none)
        begin
            res_esc_reg   <= 1'b0;
            res_kind_reg  <= 1'b0;
            res_id_reg    <= '0;
            res_cls_reg   <= CLS_NORMAL;
            res_seen_reg  <= '0;
            res_conf_reg  <= '0;
            res_fired_reg <= 1'b0;
        end

        if (ctl.out_load)
        begin
            out_esc_reg   <= res_esc_reg;
            out_kind_reg  <= res_kind_reg;
            out_id_reg    <= res_id_reg;
            out_cls_reg   <= res_cls_reg;
            out_seen_reg  <= res_seen_reg;
            out_conf_reg  <= res_conf_reg;
            out_fired_reg <= res_fired_reg;
            out_tp_reg    <= tp_reg;
            out_fp_reg    <= fp_reg;
            out_fn_reg    <= fn_reg;
            out_tn_reg    <= tn_reg;
        end
    end

    assign result_valid    = out_valid_reg;
    assign escalated       = out_esc_reg;
    assign escalation_kind = out_kind_reg;
    assign escalation_id   = out_id_reg;
    assign tentative_class = out_cls_reg;
    assign alerts_seen     = out_seen_reg;
    assign confidence      = out_conf_reg;
    assign alert_fired     = out_fired_reg;
    assign true_pos        = out_tp_reg;
    assign false_pos       = out_fp_reg;
    assign false_neg       = out_fn_reg;
    assign true_neg        = out_tn_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("window count above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> count_reg != '0)
        else $error("prune pop on empty window");

    a_clear_after_corr: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.corr_done |=> (count_reg == '0) && (head_reg == '0))
        else $error("window not cleared after correlated escalation");

    a_conf_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.corr_done |-> quo_reg <= CONF_ONE)
        else $error("correlated confidence above one");
`endif

endmodule

@@ hdl/windowed_alert_correlator_unit.sv @@
// top level of the windowed alert correlator: apb registers, controller, datapath
// sequence: an alert beat is appended to the window and its result goes to the output
//   register; a tick prunes old entries, then if the threshold is met tallies the window
//   and runs 16 divide steps, skipped when the window is empty or one class holds every entry
// items: one at a time; ticks are set by the window walk over the single read port;
//   the next item is taken while the previous result waits in the output register
// reset: async active low, window empty, counters zero, window_length 1000, threshold 5
module windowed_alert_correlator_unit #(
    parameter int WINDOW_DEPTH = wac_pkg::WINDOW_DEPTH_DEF,
    parameter int TIME_BITS    = wac_pkg::TIME_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wac_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [wac_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [wac_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic                              cmd,
    input  logic [wac_pkg::NOW_W-1:0]         now,
    input  logic [wac_pkg::CLS_W-1:0]         detected_class,
    input  logic [wac_pkg::CLS_W-1:0]         actual_class,
    input  logic                              force_escalate,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic                              escalated,
    output logic                              escalation_kind,
    output logic [wac_pkg::CTR_W-1:0]         escalation_id,
    output logic [wac_pkg::CLS_W-1:0]         tentative_class,
    output logic [wac_pkg::SEEN_W-1:0]        alerts_seen,
    output logic [wac_pkg::CONF_W-1:0]        confidence,
    output logic                              alert_fired,
    output logic [wac_pkg::CTR_W-1:0]         true_pos,
    output logic [wac_pkg::CTR_W-1:0]         false_pos,
    output logic [wac_pkg::CTR_W-1:0]         false_neg,
    output logic [wac_pkg::CTR_W-1:0]         true_neg
);
    import wac_pkg::*;

    logic [NOW_W-1:0] wlen_reg;
    logic [THR_W-1:0] thr_reg;
    logic             reg_sel;
    logic             apb_wr;
    ctl_t             ctl;
    sts_t             sts;

    assign reg_sel = paddr[2];
    assign apb_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= WLEN_RESET;
            thr_reg  <= THR_RESET;
        end
        else if (apb_wr)
        begin
            unique case (reg_sel)
                REG_WLEN: wlen_reg <= pwdata;
                REG_THR:  thr_reg  <= pwdata[THR_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_WLEN: prdata = wlen_reg;
            REG_THR:  prdata = APB_DATA_W'(thr_reg);
            default:  prdata = '0;
        endcase
    end

    wac_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .cmd        (cmd),
        .sts        (sts),
        .ctl        (ctl)
    );

    wac_dpath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .TIME_BITS    (TIME_BITS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .sts             (sts),
        .window_length   (wlen_reg),
        .alert_threshold (thr_reg),
        .now             (now),
        .detected_class  (detected_class),
        .actual_class    (actual_class),
        .force_escalate  (force_escalate),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .escalated       (escalated),
        .escalation_kind (escalation_kind),
        .escalation_id   (escalation_id),
        .tentative_class (tentative_class),
        .alerts_seen     (alerts_seen),
        .confidence      (confidence),
        .alert_fired     (alert_fired),
        .true_pos        (true_pos),
        .false_pos       (false_pos),
        .false_neg       (false_neg),
        .true_neg        (true_neg)
    );

endmodule

@@ tb/tb_top.sv @@
// testbench for the windowed alert correlator: directed and random beats, self-checking
`timescale 1ns / 100ps

module tb_top;

    import wac_pkg::*;

    localparam int          WIN_DEPTH  = WINDOW_DEPTH_DEF;
    localparam int          BEAT_COUNT = 125;
    localparam int unsigned CYCLE_CAP  = 1_500_000;
    localparam int          DRAIN_WAIT = 250;

    typedef struct packed {
        logic              escalated;
        logic              kind;
        logic [CTR_W-1:0]  id;
        logic [CLS_W-1:0]  tcls;
        logic [SEEN_W-1:0] seen;
        logic [CONF_W-1:0] conf;
        logic              fired;
        logic [CTR_W-1:0]  tp;
        logic [CTR_W-1:0]  fp;
        logic [CTR_W-1:0]  fneg;
        logic [CTR_W-1:0]  tneg;
    } verdict_t;

    class escalation_tracker;
        logic [NOW_W-1:0] slot_time [WIN_DEPTH];
        logic [CLS_W-1:0] slot_cls [WIN_DEPTH];
        int unsigned      head;
        int unsigned      fill;
        logic [CTR_W-1:0] esc_number;
        logic [CTR_W-1:0] tally [4];
        logic [NOW_W-1:0] wlen;
        logic [THR_W-1:0] thr;
        verdict_t         expected_verdicts [$];
        int               errors;
        int               alert_cnt;
        int               tick_cnt;
        int               immediate_cnt;
        int               correlated_cnt;

        function new();
            head = 0;
            fill = 0;
            esc_number = '0;
            foreach (tally[k]) tally[k] = '0;
            wlen = WLEN_RESET;
            thr = THR_RESET;
            errors = 0;
            alert_cnt = 0;
            tick_cnt = 0;
            immediate_cnt = 0;
            correlated_cnt = 0;
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction

        function logic [CTR_W-1:0] next_id();
            if (esc_number != '1)
                esc_number++;
            return esc_number;
        endfunction

        // one accepted input beat: update the window and queue the verdict it must give
        function void absorb_item(logic c, logic [NOW_W-1:0] t, logic [CLS_W-1:0] det,
                                  logic [CLS_W-1:0] act, logic esc_req);
            verdict_t         v;
            int unsigned      pos;
            int unsigned      idx;
            int unsigned      hits [5];
            int unsigned      maxc;
            logic [CLS_W-1:0] dom;
            logic [CLS_W-1:0] c_i;
            logic [NOW_W-1:0] cutoff;
            logic [63:0]      num;

            v = '0;
            if (c == CMD_ALERT) begin
                alert_cnt++;
                v.fired = (det != CLS_NORMAL);
                if (fill == WIN_DEPTH) begin
                    head = (head + 1) % WIN_DEPTH;
                    fill--;
                end
                pos = (head + fill) % WIN_DEPTH;
                slot_time[pos] = t;
                slot_cls[pos] = det;
                fill++;
                if (act != CLS_NORMAL)
                    idx = v.fired ? 0 : 2;
                else
                    idx = v.fired ? 1 : 3;
                if (tally[idx] != '1)
                    tally[idx]++;
                if (esc_req || det == CLS_R2L || det == CLS_U2R) begin
                    immediate_cnt++;
                    v.escalated = 1'b1;
                    v.kind = 1'b0;
                    v.id = next_id();
                    v.tcls = det;
                    v.seen = fill[SEEN_W-1:0];
                    v.conf = CONF_IMMEDIATE;
                end
            end else begin
                tick_cnt++;
                if (t >= wlen) begin
                    cutoff = t - wlen;
                    while (fill > 0 && slot_time[head] < cutoff) begin
                        head = (head + 1) % WIN_DEPTH;
                        fill--;
                    end
                end
                if (fill >= thr) begin
                    correlated_cnt++;
                    foreach (hits[k]) hits[k] = 0;
                    for (int i = 0; i < fill; i++) begin
                        c_i = slot_cls[(head + i) % WIN_DEPTH];
                        if (c_i >= CLS_DOS && c_i <= CLS_U2R)
                            hits[c_i]++;
                    end
                    // ties resolve toward the lower class code
                    dom = CLS_DOS;
                    maxc = hits[CLS_DOS];
                    if (hits[CLS_PROBE] > maxc) begin dom = CLS_PROBE; maxc = hits[CLS_PROBE]; end
                    if (hits[CLS_R2L] > maxc) begin dom = CLS_R2L; maxc = hits[CLS_R2L]; end
                    if (hits[CLS_U2R] > maxc) begin dom = CLS_U2R; maxc = hits[CLS_U2R]; end
                    v.escalated = 1'b1;
                    v.kind = 1'b1;
                    v.id = next_id();
                    v.tcls = dom;
                    v.seen = fill[SEEN_W-1:0];
                    num = 64'(maxc) << 16;
                    v.conf = (fill != 0) ? CONF_W'(num / fill) : '0;
                    head = 0;
                    fill = 0;
                end
            end
            v.tp = tally[0];
            v.fp = tally[1];
            v.fneg = tally[2];
            v.tneg = tally[3];
            expected_verdicts.insert(expected_verdicts.size(), v);
        endfunction

        function void cmp_field(string name, logic [63:0] e, logic [63:0] a);
            if (a !== e) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: %s expected %0h got %0h", $realtime, name, e, a);
            end
        endfunction

        function void check_verdict(verdict_t got);
            verdict_t e;
            if (expected_verdicts.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result beat with nothing outstanding", $realtime);
                return;
            end
            e = expected_verdicts[0];
            expected_verdicts.delete(0);
            cmp_field("escalated", e.escalated, got.escalated);
            cmp_field("escalation_kind", e.kind, got.kind);
            cmp_field("escalation_id", e.id, got.id);
            cmp_field("tentative_class", e.tcls, got.tcls);
            cmp_field("alerts_seen", e.seen, got.seen);
            cmp_field("confidence", e.conf, got.conf);
            cmp_field("alert_fired", e.fired, got.fired);
            cmp_field("true_pos", e.tp, got.tp);
            cmp_field("false_pos", e.fp, got.fp);
            cmp_field("false_neg", e.fneg, got.fneg);
            cmp_field("true_neg", e.tneg, got.tneg);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  item_valid;
    logic                  item_ready;
    logic                  cmd;
    logic [NOW_W-1:0]      now;
    logic [CLS_W-1:0]      detected_class;
    logic [CLS_W-1:0]      actual_class;
    logic                  force_escalate;
    logic                  result_valid;
    logic                  result_ready;
    logic                  escalated;
    logic                  escalation_kind;
    logic [CTR_W-1:0]      escalation_id;
    logic [CLS_W-1:0]      tentative_class;
    logic [SEEN_W-1:0]     alerts_seen;
    logic [CONF_W-1:0]     confidence;
    logic                  alert_fired;
    logic [CTR_W-1:0]      true_pos;
    logic [CTR_W-1:0]      false_pos;
    logic [CTR_W-1:0]      false_neg;
    logic [CTR_W-1:0]      true_neg;

    escalation_tracker tracker;
    bit                idling = 1'b1;
    int                ready_hold = 0;
    int unsigned       cycles = 0;
    int                setting_cnt = 0;

    windowed_alert_correlator_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .cmd             (cmd),
        .now             (now),
        .detected_class  (detected_class),
        .actual_class    (actual_class),
        .force_escalate  (force_escalate),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .escalated       (escalated),
        .escalation_kind (escalation_kind),
        .escalation_id   (escalation_id),
        .tentative_class (tentative_class),
        .alerts_seen     (alerts_seen),
        .confidence      (confidence),
        .alert_fired     (alert_fired),
        .true_pos        (true_pos),
        .false_pos       (false_pos),
        .false_neg       (false_neg),
        .true_neg        (true_neg)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: check each beat, stall in random bursts while idling is set
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            tracker.check_verdict({escalated, escalation_kind, escalation_id, tentative_class,
                                   alerts_seen, confidence, alert_fired, true_pos, false_pos,
                                   false_neg, true_neg});
        if (!rst_n) begin
            result_ready <= 1'b0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            result_ready <= 1'b0;
        end else if (idling && $urandom_range(0, 7) == 0) begin
            ready_hold <= $urandom_range(0, 13);
            result_ready <= 1'b0;
        end else begin
            result_ready <= 1'b1;
        end
    end

    task automatic send_item(input logic c, input logic [NOW_W-1:0] t,
                             input logic [CLS_W-1:0] det, input logic [CLS_W-1:0] act,
                             input logic esc_req);
        int gap;
        if (idling && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        cmd <= c;
        now <= t;
        detected_class <= det;
        actual_class <= act;
        force_escalate <= esc_req;
        do
            @(posedge clk);
        while (!item_ready);
        tracker.absorb_item(c, t, det, act, esc_req);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(input logic [NOW_W-1:0] wl, input logic [THR_W-1:0] th);
        wait_drained();
        apb_write({REG_WLEN, 2'b00}, wl);
        tracker.wlen = wl;
        apb_write({REG_THR, 2'b00}, APB_DATA_W'(th));
        tracker.thr = th;
        setting_cnt++;
    endtask

    // mostly monotonic time with attack-heavy alerts, some stray timestamps and odd codes
    task automatic run_phase(input logic [NOW_W-1:0] wl, input logic [THR_W-1:0] th, input int n);
        logic [NOW_W-1:0] t;
        logic [NOW_W-1:0] t_item;
        logic [63:0]      nxt;
        logic [CLS_W-1:0] det;
        logic [CLS_W-1:0] act;
        logic             c;
        int unsigned      span;
        int unsigned      pick;
        configure(wl, th);
        t = $urandom_range(0, 32'h7FFF_FFFF);
        for (int i = 0; i < n; i++) begin
            span = (wl > 32'd16_000_000) ? 1_000_000 : wl / 16 + 1;
            if ($urandom_range(0, 24) == 0)
                span = span * 24;
            nxt = {32'd0, t} + $urandom_range(0, span);
            t = (nxt > 64'h0000_0000_FFFF_FFFF) ? '1 : nxt[NOW_W-1:0];
            t_item = ($urandom_range(0, 19) == 0) ? $urandom : t;
            c = ($urandom_range(0, th / 2 + 6) == 0) ? CMD_TICK : CMD_ALERT;
            pick = $urandom_range(0, 19);
            if (pick < 5)
                det = CLS_NORMAL;
            else if (pick < 18)
                det = CLS_W'($urandom_range(CLS_DOS, CLS_U2R));
            else
                det = CLS_W'($urandom_range(5, 7));
            act = ($urandom_range(0, 9) < 7) ? det : CLS_W'($urandom_range(0, 7));
            send_item(c, t_item, det, act, $urandom_range(0, 11) == 0);
        end
    endtask

    initial
    begin
        tracker = new();
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        item_valid <= 1'b0;
        cmd <= CMD_ALERT;
        now <= '0;
        detected_class <= CLS_NORMAL;
        actual_class <= CLS_NORMAL;
        force_escalate <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one beat per confusion quadrant, immediate escalations
        send_item(CMD_ALERT, 32'd0, CLS_NORMAL, CLS_NORMAL, 1'b0);
        send_item(CMD_ALERT, 32'd10, CLS_DOS, CLS_NORMAL, 1'b0);
        send_item(CMD_ALERT, 32'd20, CLS_NORMAL, CLS_U2R, 1'b0);
        send_item(CMD_ALERT, 32'd30, CLS_PROBE, CLS_PROBE, 1'b0);
        send_item(CMD_ALERT, 32'd40, CLS_R2L, CLS_R2L, 1'b0);
        send_item(CMD_ALERT, 32'd50, CLS_U2R, CLS_DOS, 1'b0);
        send_item(CMD_ALERT, 32'd60, CLS_NORMAL, CLS_NORMAL, 1'b1);
        // undefined class codes count as attacks but never win a tally
        send_item(CMD_ALERT, 32'd70, 3'd7, 3'd7, 1'b0);
        send_item(CMD_ALERT, 32'd80, 3'd5, 3'd6, 1'b1);
        // now below window length: nothing pruned, four-way tie goes to dos
        send_item(CMD_TICK, 32'd500, CLS_U2R, CLS_U2R, 1'b1);
        send_item(CMD_TICK, 32'd600, CLS_NORMAL, CLS_NORMAL, 1'b0);
        // stray older timestamp behind a fresh head survives a prune that stops at that head
        send_item(CMD_ALERT, 32'd6000, CLS_DOS, CLS_DOS, 1'b0);
        send_item(CMD_ALERT, 32'd3000, CLS_PROBE, CLS_PROBE, 1'b0);
        send_item(CMD_ALERT, 32'd6100, CLS_PROBE, CLS_PROBE, 1'b0);
        send_item(CMD_TICK, 32'd6500, CLS_NORMAL, CLS_NORMAL, 1'b0);
        send_item(CMD_ALERT, 32'd6200, CLS_NORMAL, CLS_NORMAL, 1'b0);
        send_item(CMD_ALERT, 32'd6300, CLS_NORMAL, CLS_DOS, 1'b0);
        send_item(CMD_TICK, 32'd7100, CLS_NORMAL, CLS_NORMAL, 1'b0);
        // window of normal traffic only at the top of the time range
        repeat (5) send_item(CMD_ALERT, 32'hFFFF_FFFF, CLS_NORMAL, CLS_NORMAL, 1'b0);
        send_item(CMD_TICK, 32'hFFFF_FFFF, CLS_NORMAL, CLS_NORMAL, 1'b0);
        // zero threshold on an empty window still escalates
        configure(WLEN_RESET, 7'd0);
        send_item(CMD_TICK, 32'hFFFF_FFFF, CLS_NORMAL, CLS_NORMAL, 1'b0);

        run_phase(32'd1000, 7'd0, BEAT_COUNT);
        run_phase(32'd1, 7'd1, BEAT_COUNT);
        run_phase(32'hFFFF_FFFF, 7'd64, BEAT_COUNT);
        run_phase(32'd50, 7'd3, BEAT_COUNT);
        run_phase(32'd20000, 7'd127, BEAT_COUNT);
        run_phase(32'd300, 7'd10, BEAT_COUNT);
        idling = 1'b0;
        run_phase(32'd7, 7'd2, BEAT_COUNT);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("%0d alerts, %0d ticks over %0d register settings", tracker.alert_cnt,
                 tracker.tick_cnt, setting_cnt);
        $display("%0d immediate and %0d window escalations, %0d field errors",
                 tracker.immediate_cnt, tracker.correlated_cnt, tracker.errors);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
hdl/wac_pkg.sv
hdl/wac_ctrl.sv
hdl/wac_dpath.sv
hdl/windowed_alert_correlator_unit.sv
tb/tb_top.sv
